>>> design/fbfl_pkg.sv
// fbfl_pkg: shared types and constants for the fixed block free list allocator
// no dependencies; used by the allocator top level, its arithmetic unit and checker
`default_nettype none

package fbfl_pkg;

    localparam int ADDR_W    = 32;
    localparam int BSIZE_W   = 17;
    localparam int CHUNK_W   = 11;
    localparam int OP_W      = 2;
    localparam int CFG_IDX_W = 2;

    localparam logic [BSIZE_W-1:0] BS_MIN   = 17'd8;
    localparam logic [BSIZE_W-1:0] BS_MAX   = 17'd65536;
    localparam logic [BSIZE_W-1:0] BS_RESET = 17'd64;
    localparam logic [CHUNK_W-1:0] CHUNK_RESET = 11'd64;

    typedef enum logic [OP_W-1:0] {
        OP_ALLOC   = 2'd0,
        OP_FREE    = 2'd1,
        OP_RELEASE = 2'd2
    } t_op;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_BASE_ADDRESS  = 2'd0,
        CFG_BLOCK_SIZE    = 2'd1,
        CFG_CHUNK_ENTRIES = 2'd2
    } t_cfg_reg;

    typedef enum logic {
        AU_MUL = 1'b0,
        AU_DIV = 1'b1
    } t_au_mode;

    typedef struct packed {
        logic     start;
        t_au_mode mode;
    } t_au_cmd;

endpackage

`default_nettype wire

>>> design/fixed_block_free_list_allocator_unit.sv
// fixed_block_free_list_allocator_unit: allocate at list head, growing first by one chunk
// if empty (failing when the chunk does not fit); free through the offset divide (skipped
// when far outside the pool); release all and unknown op go straight to the result; one
// request at a time, next input transfer the cycle after the result is loaded; allocate
// and free run through the shared shift-add unit and the link ram. sync active-low reset
// empties the pool and restores register defaults; link ram contents are not cleared
`default_nettype none

module fixed_block_free_list_allocator_unit #(
    parameter int MAX_BLOCKS = 1024
) (
    input  wire logic                                 i_clk,
    input  wire logic                                 i_rst_n,
    input  wire logic                                 i_cfg_we,
    input  wire logic [fbfl_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  wire logic [fbfl_pkg::ADDR_W-1:0]          i_cfg_data,
    input  wire logic                                 i_in_valid,
    output logic                                      o_in_ready,
    input  wire logic [fbfl_pkg::OP_W-1:0]            i_op,
    input  wire logic [fbfl_pkg::ADDR_W-1:0]          i_address,
    output logic                                      o_out_valid,
    input  wire logic                                 i_out_ready,
    output logic      [fbfl_pkg::ADDR_W-1:0]          o_block_address,
    output logic                                      o_ok,
    output logic      [$clog2(MAX_BLOCKS+1)-1:0]      o_available_count
);

    localparam int IW  = $clog2(MAX_BLOCKS + 1);
    localparam int AW  = $clog2(MAX_BLOCKS);
    localparam int CHW = fbfl_pkg::CHUNK_W;
    localparam int SW  = ((IW > CHW) ? IW : CHW) + 1;
    localparam int DW  = fbfl_pkg::ADDR_W;
    localparam logic [IW-1:0] END_IDX = IW'(MAX_BLOCKS);

    typedef enum logic [2:0] {
        S_IDLE,
        S_GROW,
        S_POP_RD,
        S_POP_MUL,
        S_FREE_CHK,
        S_FREE_DIV,
        S_DONE
    } t_state;

    t_state                        r_state;
    logic [DW-1:0]                 r_base;
    logic [fbfl_pkg::BSIZE_W-1:0]  r_bsize;
    logic [CHW-1:0]                r_chunk;
    logic [IW-1:0]                 r_head;
    logic [IW-1:0]                 r_count;
    logic [IW-1:0]                 r_grown;
    logic [IW-1:0]                 r_widx;
    logic [CHW-1:0]                r_left;
    logic [DW-1:0]                 r_off;
    logic [DW-1:0]                 r_res_addr;
    logic                          r_res_ok;
    logic                          r_out_valid;
    logic [DW-1:0]                 r_out_addr;
    logic                          r_out_ok;
    logic [IW-1:0]                 r_out_count;

    logic [fbfl_pkg::BSIZE_W-1:0]  eff_bs;
    logic [CHW-1:0]                eff_chunk;
    logic [SW-1:0]                 grow_sum;
    logic [SW-1:0]                 cnt_sum;
    logic                          grow_fits;
    logic [IW-1:0]                 cnt_grow;
    logic [DW-1:0]                 off_hi;
    logic                          off_ok;
    logic                          in_xfer;

    fbfl_pkg::t_au_cmd             au_cmd;
    logic [IW-1:0]                 au_bits_in;
    logic [DW-1:0]                 au_acc_in;
    logic                          au_done;
    logic [DW-1:0]                 au_acc;
    logic [IW-1:0]                 au_bits;

    logic                          ram_we;
    logic [AW-1:0]                 ram_waddr;
    logic [IW-1:0]                 ram_wdata;
    logic                          ram_re;
    logic [IW-1:0]                 ram_rdata;

    always_comb begin
        if (r_bsize < fbfl_pkg::BS_MIN) begin
            eff_bs = fbfl_pkg::BS_MIN;
        end else if (r_bsize > fbfl_pkg::BS_MAX) begin
            eff_bs = fbfl_pkg::BS_MAX;
        end else begin
            eff_bs = r_bsize;
        end
        eff_chunk = (r_chunk == '0) ? CHW'(1) : r_chunk;
        grow_sum  = SW'(r_grown) + SW'(eff_chunk);
        cnt_sum   = SW'(r_count) + SW'(eff_chunk);
        grow_fits = (grow_sum <= SW'(MAX_BLOCKS));
        cnt_grow  = (cnt_sum > SW'(MAX_BLOCKS)) ? END_IDX : cnt_sum[IW-1:0];
        off_hi    = r_off >> IW;
        off_ok    = (off_hi < DW'(eff_bs));
        in_xfer   = i_in_valid && (r_state == S_IDLE);
    end

    // shared unit start: index multiply on pop, offset divide on free
    always_comb begin
        au_cmd.start = 1'b0;
        au_cmd.mode  = fbfl_pkg::AU_MUL;
        au_bits_in   = r_head;
        au_acc_in    = '0;
        if (r_state == S_POP_RD) begin
            au_cmd.start = 1'b1;
        end else if (r_state == S_FREE_CHK && off_ok) begin
            au_cmd.start = 1'b1;
            au_cmd.mode  = fbfl_pkg::AU_DIV;
            au_bits_in   = r_off[IW-1:0];
            au_acc_in    = off_hi;
        end
    end

    always_comb begin
        ram_re    = (r_state == S_POP_RD);
        ram_we    = 1'b0;
        ram_waddr = r_widx[AW-1:0];
        ram_wdata = (r_left == CHW'(1)) ? END_IDX : r_widx + IW'(1);
        if (r_state == S_GROW) begin
            ram_we = 1'b1;
        end else if (r_state == S_FREE_DIV && au_done && au_bits < r_grown) begin
            ram_we    = 1'b1;
            ram_waddr = au_bits[AW-1:0];
            ram_wdata = r_head;
        end
    end

    fbfl_shift_add_unit #(
        .IW (IW)
    ) u_au (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cmd     (au_cmd),
        .i_bits    (au_bits_in),
        .i_acc     (au_acc_in),
        .i_divisor (eff_bs),
        .o_done    (au_done),
        .o_acc     (au_acc),
        .o_bits    (au_bits)
    );

    fbfl_ram #(
        .WIDTH (IW),
        .DEPTH (MAX_BLOCKS)
    ) u_link_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (r_head[AW-1:0]),
        .o_rdata (ram_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_base      <= '0;
            r_bsize     <= fbfl_pkg::BS_RESET;
            r_chunk     <= fbfl_pkg::CHUNK_RESET;
            r_head      <= END_IDX;
            r_count     <= '0;
            r_grown     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                unique case (fbfl_pkg::t_cfg_reg'(i_cfg_index))
                    fbfl_pkg::CFG_BASE_ADDRESS:  r_base  <= i_cfg_data;
                    fbfl_pkg::CFG_BLOCK_SIZE:    r_bsize <= i_cfg_data[fbfl_pkg::BSIZE_W-1:0];
                    fbfl_pkg::CFG_CHUNK_ENTRIES: r_chunk <= i_cfg_data[CHW-1:0];
                    default: ;
                endcase
            end

            if (r_out_valid && i_out_ready && r_state != S_DONE) begin
                r_out_valid <= 1'b0;
            end

            unique case (r_state)
                S_IDLE: begin
                    if (in_xfer) begin
                        r_off      <= i_address - r_base;
                        r_res_addr <= '0;
                        r_res_ok   <= 1'b0;
                        unique case (fbfl_pkg::t_op'(i_op))
                            fbfl_pkg::OP_ALLOC: begin
                                if (r_head != END_IDX) begin
                                    r_state <= S_POP_RD;
                                end else if (grow_fits) begin
                                    r_widx  <= r_grown;
                                    r_left  <= eff_chunk;
                                    r_state <= S_GROW;
                                end else begin
                                    r_state <= S_DONE;
                                end
                            end
                            fbfl_pkg::OP_FREE: begin
                                r_state <= S_FREE_CHK;
                            end
                            fbfl_pkg::OP_RELEASE: begin
                                r_head   <= END_IDX;
                                r_count  <= '0;
                                r_grown  <= '0;
                                r_res_ok <= 1'b1;
                                r_state  <= S_DONE;
                            end
                            default: begin
                                r_state <= S_DONE;
                            end
                        endcase
                    end
                end
                S_GROW: begin
                    if (r_left == CHW'(1)) begin
                        r_head  <= r_grown;
                        r_grown <= r_widx + IW'(1);
                        r_count <= cnt_grow;
                        r_state <= S_POP_RD;
                    end else begin
                        r_widx <= r_widx + IW'(1);
                        r_left <= r_left - CHW'(1);
                    end
                end
                S_POP_RD: begin
                    r_state <= S_POP_MUL;
                end
                S_POP_MUL: begin
                    if (au_done) begin
                        r_head     <= ram_rdata;
                        r_res_addr <= r_base + au_acc;
                        r_res_ok   <= 1'b1;
                        r_count    <= (r_count != '0) ? r_count - IW'(1) : '0;
                        r_state    <= S_DONE;
                    end
                end
                S_FREE_CHK: begin
                    r_state <= off_ok ? S_FREE_DIV : S_DONE;
                end
                S_FREE_DIV: begin
                    if (au_done) begin
                        if (au_bits < r_grown) begin
                            r_head   <= au_bits;
                            r_count  <= (r_count == END_IDX) ? END_IDX : r_count + IW'(1);
                            r_res_ok <= 1'b1;
                        end
                        r_state <= S_DONE;
                    end
                end
                S_DONE: begin
                    if (!r_out_valid || i_out_ready) begin
                        r_out_valid <= 1'b1;
                        r_out_addr  <= r_res_addr;
                        r_out_ok    <= r_res_ok;
                        r_out_count <= r_count;
                        r_state     <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_in_ready        = (r_state == S_IDLE);
    assign o_out_valid       = r_out_valid;
    assign o_block_address   = r_out_addr;
    assign o_ok              = r_out_ok;
    assign o_available_count = r_out_count;

endmodule

`default_nettype wire

>>> design/fbfl_ram.sv
// fbfl_ram: generic single write port, single read port ram with registered read
// no dependencies
`default_nettype none

module fbfl_ram #(
    parameter int WIDTH = 11,
    parameter int DEPTH = 1024
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

`default_nettype wire

>>> design/fbfl_shift_add_unit.sv
// fbfl_shift_add_unit: shared one-bit-per-cycle multiply (shift-add) and
// restoring divide (shift-subtract) unit; depends on fbfl_pkg
`default_nettype none

module fbfl_shift_add_unit #(
    parameter int IW = 11
) (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire fbfl_pkg::t_au_cmd                  i_cmd,
    input  wire logic [IW-1:0]                      i_bits,
    input  wire logic [fbfl_pkg::ADDR_W-1:0]        i_acc,
    input  wire logic [fbfl_pkg::BSIZE_W-1:0]       i_divisor,
    output logic                                    o_done,
    output logic      [fbfl_pkg::ADDR_W-1:0]        o_acc,
    output logic      [IW-1:0]                      o_bits
);

    localparam int AW = fbfl_pkg::ADDR_W;
    localparam int CW = (IW > 1) ? $clog2(IW) : 1;

    logic                          r_busy;
    logic                          r_done;
    fbfl_pkg::t_au_mode            r_mode;
    logic [CW-1:0]                 r_cnt;
    logic [AW-1:0]                 r_acc;
    logic [IW-1:0]                 r_bits;
    logic [fbfl_pkg::BSIZE_W-1:0]  r_div;

    logic          is_div;
    logic          in_bit;
    logic [AW-1:0] sh;
    logic [AW-1:0] addend;
    logic [AW:0]   sum;
    logic          carry;
    logic [AW-1:0] n_acc;
    logic [IW-1:0] n_bits;

    always_comb begin
        is_div = (r_mode == fbfl_pkg::AU_DIV);
        in_bit = r_bits[IW-1];
        sh     = {r_acc[AW-2:0], is_div & in_bit};
        if (is_div) begin
            addend = ~AW'(r_div);
        end else if (in_bit) begin
            addend = AW'(r_div);
        end else begin
            addend = '0;
        end
        sum    = {1'b0, sh} + {1'b0, addend} + (AW+1)'(is_div);
        carry  = sum[AW];
        n_acc  = (is_div && !carry) ? sh : sum[AW-1:0];
        n_bits = {r_bits[IW-2:0], is_div & carry};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_cmd.start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
                r_mode <= i_cmd.mode;
                r_acc  <= i_acc;
                r_bits <= i_bits;
                r_div  <= i_divisor;
            end else if (r_busy) begin
                r_acc  <= n_acc;
                r_bits <= n_bits;
                if (r_cnt == CW'(IW - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end else begin
                    r_cnt <= r_cnt + CW'(1);
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_acc  = r_acc;
    assign o_bits = r_bits;

endmodule

`default_nettype wire

>>> design/fbfl_checker.sv
// fbfl_checker: port-level assertions for the allocator, bound to its top level
// depends on fixed_block_free_list_allocator_unit
`default_nettype none

module fbfl_checker #(
    parameter int MAX_BLOCKS = 1024
) (
    input wire logic                                i_clk,
    input wire logic                                i_rst_n,
    input wire logic                                i_in_valid,
    input wire logic                                o_in_ready,
    input wire logic                                o_out_valid,
    input wire logic                                i_out_ready,
    input wire logic [fbfl_pkg::ADDR_W-1:0]         o_block_address,
    input wire logic                                o_ok,
    input wire logic [$clog2(MAX_BLOCKS+1)-1:0]     o_available_count
);

    localparam int IW = $clog2(MAX_BLOCKS + 1);

    // result held until its transfer
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_block_address))
        else $error("result dropped or changed before transfer");

    // ready drops in the cycle after an input transfer
    a_busy_after_xfer: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready |=> !o_in_ready)
        else $error("ready right after an input transfer");

    a_fail_zero_addr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_ok |-> o_block_address == '0)
        else $error("failed request carries an address");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_available_count <= IW'(MAX_BLOCKS))
        else $error("free count above pool capacity");

    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid && o_in_ready)
        else $error("reset left a result or busy state");

endmodule

bind fixed_block_free_list_allocator_unit fbfl_checker #(
    .MAX_BLOCKS (MAX_BLOCKS)
) u_fbfl_checker (
    .i_clk             (i_clk),
    .i_rst_n           (i_rst_n),
    .i_in_valid        (i_in_valid),
    .o_in_ready        (o_in_ready),
    .o_out_valid       (o_out_valid),
    .i_out_ready       (i_out_ready),
    .o_block_address   (o_block_address),
    .o_ok              (o_ok),
    .o_available_count (o_available_count)
);

`default_nettype wire
